// File: hdl/ectp_pkg.sv
// Shared widths, status codes and helpers for the equal circle tangent point core.
package ectp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int XW    = 32;
  localparam int RW    = 31;
  localparam int DW    = XW + 1;
  localparam int SW    = 2 * DW;
  localparam int SQ_STEPS = SW / 2;
  localparam int SRW   = SQ_STEPS;
  localparam int RMW   = SRW + 3;
  localparam int PRW   = DW + SRW + 1;
  localparam int NW    = PRW + 1;
  localparam int AW    = NW - 1;
  localparam int LOW   = AW / 2;
  localparam int HIW   = AW - LOW;
  localparam int MW    = AW + RW;
  localparam int DENW  = SW + 1;
  localparam int QB    = XW;
  localparam int EW    = QB + DENW;
  localparam int LANES = 4;
  localparam int OFW   = QB + 2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_COIN  = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;

  localparam logic signed [OFW-1:0] SAT_HI = OFW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [OFW-1:0] SAT_LO = -SAT_HI - OFW'(1);

  typedef struct packed {
    logic signed [XW-1:0] x1;
    logic signed [XW-1:0] y1;
    logic signed [XW-1:0] x2;
    logic signed [XW-1:0] y2;
    logic signed [XW-1:0] mx;
    logic signed [XW-1:0] my;
    logic [RW-1:0]        r;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [SW-1:0]        s;
    logic                 coin;
    logic                 inner;
    logic                 clamp;
  } side_t;

  function automatic logic [XW-1:0] sat_coord(input logic signed [OFW-1:0] v);
    logic signed [OFW-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[XW-1:0];
  endfunction

  function automatic logic signed [OFW-1:0] add_off(input logic signed [XW-1:0] b,
                                                    input logic signed [OFW-1:0] o);
    return $signed({{(OFW-XW){b[XW-1]}}, b}) + o;
  endfunction

endpackage

// File: hdl/equal_circle_tangent_points_core.sv
// Top level: pipelined common tangent points of two equal circles.
//
// An item (two circles, centre and radius each) is taken at a rising edge
// where start is high and busy is low. The pipeline never stalls, so busy
// stays low and a new item may enter in every cycle.
// Each item gives one result on the out_ ports, shown for exactly one cycle
// with out_strobe high; results leave in the order the items entered.
// From the accepting edge to the strobe cycle, three stages form the
// squared centre distance, 33 stages take the integer square root one
// root bit at a time, six stages form and scale the four numerators,
// 32 stages run four restoring dividers one quotient bit each, and one
// stage adds offsets, saturates and registers the result.
// Throughput is one item per cycle.
// The receiver cannot hold results off; each result is valid only in its
// strobe cycle.
// A synchronous reset clears every valid bit, so no result appears after
// reset until a new item is taken; items in flight at reset are dropped.
module equal_circle_tangent_points_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [ectp_pkg::XW-1:0] in_first_center_x,
  input  logic signed [ectp_pkg::XW-1:0] in_first_center_y,
  input  logic [ectp_pkg::RW-1:0]        in_first_radius,
  input  logic signed [ectp_pkg::XW-1:0] in_second_center_x,
  input  logic signed [ectp_pkg::XW-1:0] in_second_center_y,
  input  logic [ectp_pkg::RW-1:0]        in_second_radius,
  output logic                           out_strobe,
  output logic signed [ectp_pkg::XW-1:0] out_line_a_start_x,
  output logic signed [ectp_pkg::XW-1:0] out_line_a_start_y,
  output logic signed [ectp_pkg::XW-1:0] out_line_a_end_x,
  output logic signed [ectp_pkg::XW-1:0] out_line_a_end_y,
  output logic signed [ectp_pkg::XW-1:0] out_line_b_start_x,
  output logic signed [ectp_pkg::XW-1:0] out_line_b_start_y,
  output logic signed [ectp_pkg::XW-1:0] out_line_b_end_x,
  output logic signed [ectp_pkg::XW-1:0] out_line_b_end_y,
  output logic                           out_crossing_kind,
  output logic [1:0]                     out_status
);
  import ectp_pkg::*;

  assign busy = 1'b0;

  // Stage 1: differences and radius sums.
  logic                 v1_r;
  side_t                sd1_r;
  logic [DW-1:0]        ax1_r, ay1_r;
  logic [XW-1:0]        sumr1_r, twor1_r;
  logic signed [DW-1:0] dx_nxt, dy_nxt;

  always_comb begin
    dx_nxt = $signed({in_second_center_x[XW-1], in_second_center_x})
           - $signed({in_first_center_x[XW-1], in_first_center_x});
    dy_nxt = $signed({in_second_center_y[XW-1], in_second_center_y})
           - $signed({in_first_center_y[XW-1], in_first_center_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    sd1_r.x1    <= in_first_center_x;
    sd1_r.y1    <= in_first_center_y;
    sd1_r.x2    <= in_second_center_x;
    sd1_r.y2    <= in_second_center_y;
    sd1_r.mx    <= '0;
    sd1_r.my    <= '0;
    sd1_r.r     <= in_first_radius;
    sd1_r.dx    <= dx_nxt;
    sd1_r.dy    <= dy_nxt;
    sd1_r.s     <= '0;
    sd1_r.coin  <= 1'b0;
    sd1_r.inner <= 1'b0;
    sd1_r.clamp <= 1'b0;
    ax1_r   <= dx_nxt[DW-1] ? DW'(-dx_nxt) : DW'(dx_nxt);
    ay1_r   <= dy_nxt[DW-1] ? DW'(-dy_nxt) : DW'(dy_nxt);
    sumr1_r <= XW'({1'b0, in_first_radius}) + XW'({1'b0, in_second_radius});
    twor1_r <= {in_first_radius, 1'b0};
  end

  // Stage 2: squares and midpoint.
  logic           v2_r;
  side_t          sd2_r;
  side_t          sd2_nxt;
  logic [SW-1:0]  sqx2_r, sqy2_r;
  logic [2*XW-1:0] sum2_r, four2_r;
  logic [DW-1:0]  hx_nxt, hy_nxt;
  logic signed [OFW-1:0] mx_nxt, my_nxt;

  always_comb begin
    hx_nxt = DW'((ax1_r + DW'(1)) >> 1);
    hy_nxt = DW'((ay1_r + DW'(1)) >> 1);
    mx_nxt = add_off(sd1_r.x1, sd1_r.dx[DW-1] ? -$signed({1'b0, hx_nxt})
                                             : $signed({1'b0, hx_nxt}));
    my_nxt = add_off(sd1_r.y1, sd1_r.dy[DW-1] ? -$signed({1'b0, hy_nxt})
                                             : $signed({1'b0, hy_nxt}));
    sd2_nxt    = sd1_r;
    sd2_nxt.mx = mx_nxt[XW-1:0];
    sd2_nxt.my = my_nxt[XW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    sd2_r    <= sd2_nxt;
    sqx2_r   <= ax1_r * ax1_r;
    sqy2_r   <= ay1_r * ay1_r;
    sum2_r   <= sumr1_r * sumr1_r;
    four2_r  <= twor1_r * twor1_r;
  end

  // Stage 3: squared distance, case decision and root operand.
  logic          v3_r;
  side_t         sd3_r;
  side_t         sd3_nxt;
  logic [SW-1:0] sqop3_r;
  logic [SW-1:0] s_nxt;
  logic          coin_nxt, inner_nxt, clamp_nxt;

  always_comb begin
    s_nxt     = sqx2_r + sqy2_r;
    coin_nxt  = (s_nxt == '0);
    inner_nxt = !coin_nxt && (s_nxt >= SW'(sum2_r));
    clamp_nxt = inner_nxt && (s_nxt < SW'(four2_r));
    sd3_nxt       = sd2_r;
    sd3_nxt.s     = s_nxt;
    sd3_nxt.coin  = coin_nxt;
    sd3_nxt.inner = inner_nxt;
    sd3_nxt.clamp = clamp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    sd3_r <= sd3_nxt;
    if (clamp_nxt) begin
      sqop3_r <= '0;
    end else if (inner_nxt) begin
      sqop3_r <= s_nxt - SW'(four2_r);
    end else begin
      sqop3_r <= s_nxt;
    end
  end

  // Square root pipeline, one root bit per stage.
  logic           sq_v_r    [SQ_STEPS];
  side_t          sq_sd_r   [SQ_STEPS];
  logic [RMW-1:0] sq_rem_r  [SQ_STEPS];
  logic [SRW-1:0] sq_root_r [SQ_STEPS];
  logic [SW-1:0]  sq_n_r    [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    logic           v_in;
    side_t          sd_in;
    logic [RMW-1:0] rem_in, rem_t, trial;
    logic [SRW-1:0] root_in;
    logic [SW-1:0]  n_in;
    logic           ge;

    if (j == 0) begin : g_first
      assign v_in    = v3_r;
      assign sd_in   = sd3_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = sqop3_r;
    end else begin : g_next
      assign v_in    = sq_v_r[j-1];
      assign sd_in   = sq_sd_r[j-1];
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign n_in    = sq_n_r[j-1];
    end

    always_comb begin
      rem_t = {rem_in[RMW-3:0], n_in[SW-1:SW-2]};
      trial = RMW'({root_in, 2'b01});
      ge    = (rem_t >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else begin
        sq_v_r[j] <= v_in;
      end
      sq_sd_r[j]   <= sd_in;
      sq_rem_r[j]  <= ge ? (rem_t - trial) : rem_t;
      sq_root_r[j] <= {root_in[SRW-2:0], ge};
      sq_n_r[j]    <= {n_in[SW-3:0], 2'b00};
    end
  end

  // Stage M1: products with the root and with the doubled radius.
  logic                  vm1_r;
  side_t                 sdm1_r;
  logic signed [PRW-1:0] ra1_r, rb1_r, ta1_r, tb1_r;
  logic [SW-1:0]         dm1_r;
  logic [SRW-1:0]        root_l;
  side_t                 sdl;

  assign root_l = sq_root_r[SQ_STEPS-1];
  assign sdl    = sq_sd_r[SQ_STEPS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
    end else begin
      vm1_r <= sq_v_r[SQ_STEPS-1];
    end
    sdm1_r <= sdl;
    ra1_r  <= sdl.dx * $signed({1'b0, sdl.r, 1'b0});
    rb1_r  <= sdl.dy * $signed({1'b0, sdl.r, 1'b0});
    ta1_r  <= sdl.dx * $signed({1'b0, root_l});
    tb1_r  <= sdl.dy * $signed({1'b0, root_l});
    dm1_r  <= sdl.inner ? sdl.s : SW'(root_l);
  end

  // Stage M2: numerators.
  logic                 vm2_r;
  side_t                sdm2_r;
  logic signed [NW-1:0] nm2_r [LANES];
  logic [SW-1:0]        dm2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm2_r <= 1'b0;
    end else begin
      vm2_r <= vm1_r;
    end
    sdm2_r <= sdm1_r;
    dm2_r  <= dm1_r;
    if (sdm1_r.inner) begin
      nm2_r[0] <= $signed({ra1_r[PRW-1], ra1_r}) + $signed({tb1_r[PRW-1], tb1_r});
      nm2_r[1] <= $signed({rb1_r[PRW-1], rb1_r}) - $signed({ta1_r[PRW-1], ta1_r});
      nm2_r[2] <= $signed({ra1_r[PRW-1], ra1_r}) - $signed({tb1_r[PRW-1], tb1_r});
      nm2_r[3] <= $signed({rb1_r[PRW-1], rb1_r}) + $signed({ta1_r[PRW-1], ta1_r});
    end else begin
      nm2_r[0] <= -$signed({{(NW-DW){sdm1_r.dy[DW-1]}}, sdm1_r.dy});
      nm2_r[1] <= $signed({{(NW-DW){sdm1_r.dx[DW-1]}}, sdm1_r.dx});
      nm2_r[2] <= '0;
      nm2_r[3] <= '0;
    end
  end

  // Stage M3: magnitudes and signs.
  logic          vm3_r;
  side_t         sdm3_r;
  logic [AW-1:0] am3_r [LANES];
  logic          neg3_r [LANES];
  logic [SW-1:0] dm3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm3_r <= 1'b0;
    end else begin
      vm3_r <= vm2_r;
    end
    sdm3_r <= sdm2_r;
    dm3_r  <= dm2_r;
    for (int i = 0; i < LANES; i++) begin
      neg3_r[i] <= nm2_r[i][NW-1];
      am3_r[i]  <= nm2_r[i][NW-1] ? AW'(-nm2_r[i]) : nm2_r[i][AW-1:0];
    end
  end

  // Stage M4: partial products with the radius.
  logic              vm4_r;
  side_t             sdm4_r;
  logic [LOW+RW-1:0] lo4_r [LANES];
  logic [HIW+RW-1:0] hi4_r [LANES];
  logic              neg4_r [LANES];
  logic [SW-1:0]     dm4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm4_r <= 1'b0;
    end else begin
      vm4_r <= vm3_r;
    end
    sdm4_r <= sdm3_r;
    dm4_r  <= dm3_r;
    for (int i = 0; i < LANES; i++) begin
      neg4_r[i] <= neg3_r[i];
      lo4_r[i]  <= am3_r[i][LOW-1:0] * sdm3_r.r;
      hi4_r[i]  <= am3_r[i][AW-1:LOW] * sdm3_r.r;
    end
  end

  // Stage M5: scaled magnitudes.
  logic          vm5_r;
  side_t         sdm5_r;
  logic [MW-1:0] mm5_r [LANES];
  logic          neg5_r [LANES];
  logic [SW-1:0] dm5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm5_r <= 1'b0;
    end else begin
      vm5_r <= vm4_r;
    end
    sdm5_r <= sdm4_r;
    dm5_r  <= dm4_r;
    for (int i = 0; i < LANES; i++) begin
      neg5_r[i] <= neg4_r[i];
      mm5_r[i]  <= MW'(lo4_r[i]) + {hi4_r[i], {LOW{1'b0}}};
    end
  end

  // Stage M6: rounding numerators and the doubled divisor.
  logic            vm6_r;
  side_t           sdm6_r;
  logic [EW-1:0]   em6_r [LANES];
  logic            neg6_r [LANES];
  logic [DENW-1:0] den6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm6_r <= 1'b0;
    end else begin
      vm6_r <= vm5_r;
    end
    sdm6_r <= sdm5_r;
    den6_r <= {dm5_r, 1'b0};
    for (int i = 0; i < LANES; i++) begin
      neg6_r[i] <= neg5_r[i];
      em6_r[i]  <= {mm5_r[i], 1'b0} + EW'(dm5_r);
    end
  end

  // Divider pipeline, one quotient bit per stage in each lane.
  logic            dv_v_r   [QB];
  side_t           dv_sd_r  [QB];
  logic [DENW-1:0] dv_den_r [QB];
  logic [DENW-1:0] dv_rem_r [QB][LANES];
  logic [QB-1:0]   dv_nb_r  [QB][LANES];
  logic [QB-1:0]   dv_q_r   [QB][LANES];
  logic            dv_neg_r [QB][LANES];

  for (genvar j = 0; j < QB; j++) begin : g_dv
    logic            v_in;
    side_t           sd_in;
    logic [DENW-1:0] den_in;
    logic [DENW-1:0] rem_in [LANES];
    logic [QB-1:0]   nb_in  [LANES];
    logic [QB-1:0]   q_in   [LANES];
    logic            neg_in [LANES];
    logic [DENW:0]   t      [LANES];
    logic            ge     [LANES];

    if (j == 0) begin : g_first
      assign v_in   = vm6_r;
      assign sd_in  = sdm6_r;
      assign den_in = den6_r;
      for (genvar i = 0; i < LANES; i++) begin : g_ln
        assign rem_in[i] = em6_r[i][EW-1:QB];
        assign nb_in[i]  = em6_r[i][QB-1:0];
        assign q_in[i]   = '0;
        assign neg_in[i] = neg6_r[i];
      end
    end else begin : g_next
      assign v_in   = dv_v_r[j-1];
      assign sd_in  = dv_sd_r[j-1];
      assign den_in = dv_den_r[j-1];
      for (genvar i = 0; i < LANES; i++) begin : g_ln
        assign rem_in[i] = dv_rem_r[j-1][i];
        assign nb_in[i]  = dv_nb_r[j-1][i];
        assign q_in[i]   = dv_q_r[j-1][i];
        assign neg_in[i] = dv_neg_r[j-1][i];
      end
    end

    always_comb begin
      for (int i = 0; i < LANES; i++) begin
        t[i]  = {rem_in[i], nb_in[i][QB-1]};
        ge[i] = (t[i] >= {1'b0, den_in});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else begin
        dv_v_r[j] <= v_in;
      end
      dv_sd_r[j]  <= sd_in;
      dv_den_r[j] <= den_in;
      for (int i = 0; i < LANES; i++) begin
        dv_rem_r[j][i] <= ge[i] ? DENW'(t[i] - {1'b0, den_in}) : t[i][DENW-1:0];
        dv_nb_r[j][i]  <= {nb_in[i][QB-2:0], 1'b0};
        dv_q_r[j][i]   <= {q_in[i][QB-2:0], ge[i]};
        dv_neg_r[j][i] <= neg_in[i];
      end
    end
  end

  // Output stage: offsets, point selection and saturation.
  side_t                 sdf;
  logic signed [OFW-1:0] off [LANES];
  logic signed [OFW-1:0] pt  [8];
  logic [XW-1:0]         pc_nxt [8];
  logic [1:0]            status_nxt;

  assign sdf = dv_sd_r[QB-1];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      off[i] = dv_neg_r[QB-1][i] ? -$signed({2'b00, dv_q_r[QB-1][i]})
                                 : $signed({2'b00, dv_q_r[QB-1][i]});
    end
    if (sdf.inner) begin
      pt[0] = add_off(sdf.x1, off[0]);
      pt[1] = add_off(sdf.y1, off[1]);
      pt[2] = add_off(sdf.x2, -off[0]);
      pt[3] = add_off(sdf.y2, -off[1]);
      pt[4] = add_off(sdf.x1, off[2]);
      pt[5] = add_off(sdf.y1, off[3]);
      pt[6] = add_off(sdf.x2, -off[2]);
      pt[7] = add_off(sdf.y2, -off[3]);
    end else begin
      pt[0] = add_off(sdf.x1, off[0]);
      pt[1] = add_off(sdf.y1, off[1]);
      pt[2] = add_off(sdf.x2, off[0]);
      pt[3] = add_off(sdf.y2, off[1]);
      pt[4] = add_off(sdf.x1, -off[0]);
      pt[5] = add_off(sdf.y1, -off[1]);
      pt[6] = add_off(sdf.x2, -off[0]);
      pt[7] = add_off(sdf.y2, -off[1]);
    end
    for (int k = 0; k < 8; k++) begin
      pc_nxt[k] = sat_coord(pt[k]);
    end
    status_nxt = ST_OK;
    if (sdf.coin) begin
      pc_nxt[0] = sdf.x1;
      pc_nxt[1] = sdf.y1;
      pc_nxt[2] = sdf.x2;
      pc_nxt[3] = sdf.y2;
      pc_nxt[4] = sdf.x1;
      pc_nxt[5] = sdf.y1;
      pc_nxt[6] = sdf.x2;
      pc_nxt[7] = sdf.y2;
      status_nxt = ST_COIN;
    end else if (sdf.clamp) begin
      for (int k = 0; k < 8; k += 2) begin
        pc_nxt[k]     = sdf.mx;
        pc_nxt[k + 1] = sdf.my;
      end
      status_nxt = ST_CLAMP;
    end
  end

  logic          out_strobe_r;
  logic [XW-1:0] pc_r [8];
  logic          kind_r;
  logic [1:0]    status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_v_r[QB-1];
    end
    for (int k = 0; k < 8; k++) begin
      pc_r[k] <= pc_nxt[k];
    end
    kind_r   <= sdf.inner;
    status_r <= status_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_line_a_start_x = pc_r[0];
  assign out_line_a_start_y = pc_r[1];
  assign out_line_a_end_x   = pc_r[2];
  assign out_line_a_end_y   = pc_r[3];
  assign out_line_b_start_x = pc_r[4];
  assign out_line_b_start_y = pc_r[5];
  assign out_line_b_end_x   = pc_r[6];
  assign out_line_b_end_y   = pc_r[7];
  assign out_crossing_kind  = kind_r;
  assign out_status         = status_r;

endmodule
